### rtl/core/assert_macros.svh
// assertion helpers for the segmentation engine rtl
// expects clk and rst_n in the scope of the use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, quiet while reset is held
`define GSUF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that holds through reset as well
`define GSUF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/gsuf_pkg.sv
// shared types and constants of the union-find segmentation engine
// used by gsuf_div and graph_segmentation_union_find
`default_nettype none
package gsuf_pkg;
  localparam int unsigned NUM_VERTICES = 65536;
  localparam int unsigned VTX_W = 16;
  localparam int unsigned CNT_W = 17;
  localparam int unsigned RANK_W = 5;
  localparam int unsigned SIZE_W = 17;
  localparam int unsigned THR_W = 24;
  localparam int unsigned LBL_W = 17;
  localparam int unsigned WGT_W = 17;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic [CNT_W-1:0] NUM_V_CNT = CNT_W'(NUM_VERTICES);
  localparam logic [VTX_W-1:0] CLR_LAST = VTX_W'(NUM_VERTICES - 1);
  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;
  localparam logic [RANK_W-1:0] RANK_MAX = '1;
  localparam logic [THR_W-1:0] THR_MAX = '1;
  localparam logic [LBL_W-1:0] LBL_MAX = '1;
  localparam logic [THR_W-1:0] K_RESET = 24'd128000;
  localparam logic [SIZE_W-1:0] MIN_RESET = 17'd20;

  // register index, taken from paddr bit 2
  localparam logic REG_K = 1'b0;
  localparam logic REG_MIN = 1'b1;

  typedef enum logic [1:0] {
    CMD_THR    = 2'd0,
    CMD_SMALL  = 2'd1,
    CMD_LABEL  = 2'd2,
    CMD_REINIT = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [VTX_W-1:0]  parent;
    logic [RANK_W-1:0] rank;
    logic [SIZE_W-1:0] size;
    logic [THR_W-1:0]  thr;
    logic              lvalid;
    logic [LBL_W-1:0]  label;
  } vtx_ent_t;
endpackage
`default_nettype wire

### rtl/core/graph_segmentation_union_find.sv
// union-find segmentation engine: vertex table memory, chain walker and merge sequencer
// depends on gsuf_pkg, gsuf_div and assert_macros.svh
//
//  channel  handshake            payload
//  in       start / busy         in_command, in_vertex_a, in_vertex_b, in_edge_weight
//  out      out_valid strobe     out_merged, out_root, out_label, out_component_count
//  cfg      apb psel/penable     paddr, pwdata, prdata (pready tied high)
//
// each parent hop is a memory read (S_FIND) and then a compare (S_FCHK); an edge walks
// both chains, a merge then writes the sub root (S_JSUB) and the top root (S_JTOP), and a
// threshold merge also waits in S_DIV while the divider runs; a label walks one chain
// after each result the block returns to idle before it takes the next transfer
// reset and the reinit command sweep all 65536 vertex entries, busy throughout
// results show for one cycle and cannot be stalled
`default_nettype none
`include "assert_macros.svh"
module graph_segmentation_union_find (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_command,
  input  logic [gsuf_pkg::VTX_W-1:0]   in_vertex_a,
  input  logic [gsuf_pkg::VTX_W-1:0]   in_vertex_b,
  input  logic [gsuf_pkg::WGT_W-1:0]   in_edge_weight,
  output logic                         out_valid,
  output logic                         out_merged,
  output logic [gsuf_pkg::VTX_W-1:0]   out_root,
  output logic [gsuf_pkg::VTX_W-1:0]   out_label,
  output logic [gsuf_pkg::CNT_W-1:0]   out_component_count,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gsuf_pkg::ADDR_W-1:0]  paddr,
  input  logic [gsuf_pkg::DATA_W-1:0]  pwdata,
  output logic [gsuf_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import gsuf_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_CLEAR  = 11'b00000000010,
    S_FIND   = 11'b00000000100,
    S_FCHK   = 11'b00000001000,
    S_COMP   = 11'b00000010000,
    S_LABEL  = 11'b00000100000,
    S_DECIDE = 11'b00001000000,
    S_JSUB   = 11'b00010000000,
    S_DIV    = 11'b00100000000,
    S_JTOP   = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  vtx_ent_t vtx_mem [NUM_VERTICES];
  vtx_ent_t rd_q_r;

  state_t            state_r, state_nxt;
  logic [THR_W-1:0]  k_r;
  logic [SIZE_W-1:0] min_r;
  logic [CNT_W-1:0]  set_count_r, set_count_nxt;
  logic [LBL_W-1:0]  next_label_r, next_label_nxt;
  logic [VTX_W-1:0]  clr_idx_r, clr_idx_nxt;
  logic              reinit_r, reinit_nxt;
  logic              phase_r, phase_nxt;
  logic              first_r, first_nxt;

  cmd_t              cmd_r, cmd_nxt;
  logic [VTX_W-1:0]  vb_r, vb_nxt;
  logic [WGT_W-1:0]  w_r, w_nxt;
  logic [VTX_W-1:0]  cur_r, cur_nxt;
  logic [VTX_W-1:0]  orig_r, orig_nxt;
  vtx_ent_t          first_ent_r, first_ent_nxt;
  vtx_ent_t          ent_a_r, ent_a_nxt;
  vtx_ent_t          ent_b_r, ent_b_nxt;
  logic [VTX_W-1:0]  root_a_r, root_a_nxt;
  logic [VTX_W-1:0]  root_b_r, root_b_nxt;
  logic [VTX_W-1:0]  top_r, top_nxt;
  vtx_ent_t          top_ent_r, top_ent_nxt;
  logic              merged_r, merged_nxt;
  logic [VTX_W-1:0]  root_r, root_nxt;
  logic [VTX_W-1:0]  label_r, label_nxt;

  logic              we;
  logic [VTX_W-1:0]  wr_addr;
  vtx_ent_t          wr_data;

  logic              a_top;
  vtx_ent_t          top_ent, sub_ent;
  logic [SIZE_W:0]   size_sum;
  logic [SIZE_W-1:0] size_new;
  logic [THR_W:0]    thr_sum;
  logic              div_start, div_done;
  logic [THR_W-1:0]  div_q;
  logic              cfg_wr;

  gsuf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (k_r),
    .divisor  (size_new),
    .done     (div_done),
    .quotient (div_q)
  );

  // join rule: higher rank wins, ties put the first root under the second
  assign a_top    = ent_a_r.rank > ent_b_r.rank;
  assign top_ent  = a_top ? ent_a_r : ent_b_r;
  assign sub_ent  = a_top ? ent_b_r : ent_a_r;
  assign size_sum = {1'b0, ent_a_r.size} + {1'b0, ent_b_r.size};
  assign size_new = size_sum[SIZE_W] ? SIZE_MAX : size_sum[SIZE_W-1:0];
  assign thr_sum  = {{(THR_W + 1 - WGT_W){1'b0}}, w_r} + {1'b0, div_q};

  always_comb begin
    state_nxt      = state_r;
    set_count_nxt  = set_count_r;
    next_label_nxt = next_label_r;
    clr_idx_nxt    = clr_idx_r;
    reinit_nxt     = reinit_r;
    phase_nxt      = phase_r;
    first_nxt      = first_r;
    cmd_nxt        = cmd_r;
    vb_nxt         = vb_r;
    w_nxt          = w_r;
    cur_nxt        = cur_r;
    orig_nxt       = orig_r;
    first_ent_nxt  = first_ent_r;
    ent_a_nxt      = ent_a_r;
    ent_b_nxt      = ent_b_r;
    root_a_nxt     = root_a_r;
    root_b_nxt     = root_b_r;
    top_nxt        = top_r;
    top_ent_nxt    = top_ent_r;
    merged_nxt     = merged_r;
    root_nxt       = root_r;
    label_nxt      = label_r;
    we             = 1'b0;
    wr_addr        = orig_r;
    wr_data        = first_ent_r;
    div_start      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt    = cmd_t'(in_command);
          vb_nxt     = in_vertex_b;
          w_nxt      = in_edge_weight;
          cur_nxt    = in_vertex_a;
          orig_nxt   = in_vertex_a;
          phase_nxt  = 1'b0;
          first_nxt  = 1'b1;
          merged_nxt = 1'b0;
          root_nxt   = in_vertex_a;
          label_nxt  = '0;
          if (cmd_t'(in_command) == CMD_REINIT) begin
            clr_idx_nxt    = '0;
            reinit_nxt     = 1'b1;
            set_count_nxt  = NUM_V_CNT;
            next_label_nxt = '0;
            state_nxt      = S_CLEAR;
          end else begin
            state_nxt = S_FIND;
          end
        end
      end
      S_CLEAR: begin
        we             = 1'b1;
        wr_addr        = clr_idx_r;
        wr_data.parent = clr_idx_r;
        wr_data.rank   = '0;
        wr_data.size   = SIZE_W'(1);
        wr_data.thr    = k_r;
        wr_data.lvalid = 1'b0;
        wr_data.label  = '0;
        clr_idx_nxt    = clr_idx_r + 1'b1;
        if (clr_idx_r == CLR_LAST) begin
          state_nxt = reinit_r ? S_DONE : S_IDLE;
        end
      end
      S_FIND: begin
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (first_r) begin
          first_ent_nxt = rd_q_r;
          first_nxt     = 1'b0;
        end
        if (rd_q_r.parent == cur_r) begin
          if (phase_r) begin
            ent_b_nxt  = rd_q_r;
            root_b_nxt = cur_r;
          end else begin
            ent_a_nxt  = rd_q_r;
            root_a_nxt = cur_r;
          end
          state_nxt = S_COMP;
        end else begin
          cur_nxt   = rd_q_r.parent;
          state_nxt = S_FIND;
        end
      end
      S_COMP: begin
        // point the queried vertex straight at its root
        we             = 1'b1;
        wr_addr        = orig_r;
        wr_data.parent = phase_r ? root_b_r : root_a_r;
        if (cmd_r == CMD_LABEL) begin
          state_nxt = S_LABEL;
        end else if (!phase_r) begin
          phase_nxt = 1'b1;
          cur_nxt   = vb_r;
          orig_nxt  = vb_r;
          first_nxt = 1'b1;
          state_nxt = S_FIND;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_LABEL: begin
        root_nxt = root_a_r;
        if (!ent_a_r.lvalid) begin
          we             = 1'b1;
          wr_addr        = root_a_r;
          wr_data        = ent_a_r;
          wr_data.lvalid = 1'b1;
          wr_data.label  = next_label_r;
          label_nxt      = next_label_r[VTX_W-1:0];
          if (next_label_r != LBL_MAX) begin
            next_label_nxt = next_label_r + 1'b1;
          end
        end else begin
          label_nxt = ent_a_r.label[VTX_W-1:0];
        end
        state_nxt = S_DONE;
      end
      S_DECIDE: begin
        root_nxt  = root_a_r;
        state_nxt = S_DONE;
        if (root_a_r != root_b_r) begin
          if (cmd_r == CMD_THR) begin
            if (({{(THR_W - WGT_W){1'b0}}, w_r} <= ent_a_r.thr) &&
                ({{(THR_W - WGT_W){1'b0}}, w_r} <= ent_b_r.thr)) begin
              state_nxt = S_JSUB;
            end
          end else if ((ent_a_r.size < min_r) || (ent_b_r.size < min_r)) begin
            state_nxt = S_JSUB;
          end
        end
      end
      S_JSUB: begin
        we             = 1'b1;
        wr_addr        = a_top ? root_b_r : root_a_r;
        wr_data        = sub_ent;
        wr_data.parent = a_top ? root_a_r : root_b_r;
        top_nxt        = a_top ? root_a_r : root_b_r;
        top_ent_nxt    = top_ent;
        top_ent_nxt.size = size_new;
        if (!a_top && (ent_a_r.rank == ent_b_r.rank) && (ent_b_r.rank != RANK_MAX)) begin
          top_ent_nxt.rank = ent_b_r.rank + 1'b1;
        end
        if (set_count_r != '0) begin
          set_count_nxt = set_count_r - 1'b1;
        end
        merged_nxt = 1'b1;
        root_nxt   = a_top ? root_a_r : root_b_r;
        if (cmd_r == CMD_THR) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_JTOP;
        end
      end
      S_DIV: begin
        if (div_done) begin
          top_ent_nxt.thr = thr_sum[THR_W] ? THR_MAX : thr_sum[THR_W-1:0];
          state_nxt       = S_JTOP;
        end
      end
      S_JTOP: begin
        we        = 1'b1;
        wr_addr   = top_r;
        wr_data   = top_ent_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      vtx_mem[wr_addr] <= wr_data;
    end
    rd_q_r <= vtx_mem[cur_r];
  end

  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      k_r          <= K_RESET;
      min_r        <= MIN_RESET;
      set_count_r  <= NUM_V_CNT;
      next_label_r <= '0;
      clr_idx_r    <= '0;
      reinit_r     <= 1'b0;
      phase_r      <= 1'b0;
      first_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      set_count_r  <= set_count_nxt;
      next_label_r <= next_label_nxt;
      clr_idx_r    <= clr_idx_nxt;
      reinit_r     <= reinit_nxt;
      phase_r      <= phase_nxt;
      first_r      <= first_nxt;
      if (cfg_wr) begin
        if (paddr[2] == REG_MIN) begin
          min_r <= pwdata[SIZE_W-1:0];
        end else begin
          k_r <= pwdata[THR_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    vb_r        <= vb_nxt;
    w_r         <= w_nxt;
    cur_r       <= cur_nxt;
    orig_r      <= orig_nxt;
    first_ent_r <= first_ent_nxt;
    ent_a_r     <= ent_a_nxt;
    ent_b_r     <= ent_b_nxt;
    root_a_r    <= root_a_nxt;
    root_b_r    <= root_b_nxt;
    top_r       <= top_nxt;
    top_ent_r   <= top_ent_nxt;
    merged_r    <= merged_nxt;
    root_r      <= root_nxt;
    label_r     <= label_nxt;
  end

  assign busy                = state_r != S_IDLE;
  assign out_valid           = state_r == S_DONE;
  assign out_merged          = merged_r;
  assign out_root            = root_r;
  assign out_label           = label_r;
  assign out_component_count = set_count_r;
  assign pready              = 1'b1;
  assign prdata = (paddr[2] == REG_MIN) ? DATA_W'(min_r) : DATA_W'(k_r);

  `GSUF_ASSERT(a_strobe_single, out_valid |=> !out_valid, "result strobe held longer than a cycle")
  `GSUF_ASSERT(a_accept_busy, (start && !busy) |=> busy, "transfer accepted but block not busy")
  `GSUF_ASSERT(a_div_in_wait, div_done |-> (state_r == S_DIV),
               "divider finished outside its wait")
  `GSUF_ASSERT(a_clear_write, (state_r == S_CLEAR) |-> (we && (wr_addr == clr_idx_r)),
               "clear sweep skipped an entry")
  `GSUF_ASSERT_ALWAYS(a_pready_high, pready, "pready low on the configuration port")
endmodule
`default_nettype wire

### rtl/core/gsuf_div.sv
// restoring divider, one quotient bit per cycle: threshold constant over size
// depends on gsuf_pkg
`default_nettype none
module gsuf_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [gsuf_pkg::THR_W-1:0]  dividend,
  input  logic [gsuf_pkg::SIZE_W-1:0] divisor,
  output logic                        done,
  output logic [gsuf_pkg::THR_W-1:0]  quotient
);
  import gsuf_pkg::*;

  localparam int unsigned CW = $clog2(THR_W);
  localparam logic [CW-1:0] LAST = CW'(THR_W - 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [THR_W-1:0]  quo_r, quo_nxt;
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [SIZE_W-1:0] dsr_r, dsr_nxt;
  logic [SIZE_W:0]   rem_sh;
  logic              ge;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    rem_sh   = {rem_r, quo_r[THR_W-1]};
    ge       = rem_sh >= {1'b0, dsr_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      // remainder stays below the divisor, so it fits in SIZE_W bits
      rem_nxt = ge ? SIZE_W'(rem_sh - {1'b0, dsr_r}) : rem_sh[SIZE_W-1:0];
      quo_nxt = {quo_r[THR_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule
`default_nettype wire

### sim/tb_top.sv
// self-checking testbench of the union-find segmentation engine
// depends on gsuf_pkg and graph_segmentation_union_find; results checked against a predictor
`timescale 1ns / 100ps
module tb_top;
  import gsuf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned PHASES = 5;
  localparam int unsigned ITEMS_PER_PHASE = 90;

  typedef struct packed {
    logic              merged;
    logic [VTX_W-1:0]  root;
    logic [VTX_W-1:0]  label;
    logic [CNT_W-1:0]  count;
  } seg_res_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [VTX_W-1:0]  va;
    logic [VTX_W-1:0]  vb;
    logic [WGT_W-1:0]  w;
    logic              typed;
    seg_res_t          res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_command = '0;
  logic [VTX_W-1:0] in_vertex_a = '0;
  logic [VTX_W-1:0] in_vertex_b = '0;
  logic [WGT_W-1:0] in_edge_weight = '0;
  logic out_valid, out_merged;
  logic [VTX_W-1:0] out_root, out_label;
  logic [CNT_W-1:0] out_component_count;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  graph_segmentation_union_find DUT (.*);

  // local copy of the vertex tables
  logic [VTX_W-1:0]  m_parent [NUM_VERTICES];
  logic [RANK_W-1:0] m_rank   [NUM_VERTICES];
  logic [SIZE_W-1:0] m_size   [NUM_VERTICES];
  logic [THR_W-1:0]  m_thr    [NUM_VERTICES];
  logic [LBL_W-1:0]  m_lbl    [NUM_VERTICES];
  bit                m_lvalid [NUM_VERTICES];
  logic [CNT_W-1:0]  m_sets;
  logic [LBL_W-1:0]  m_next_lbl;
  logic [THR_W-1:0]  k_reg = K_RESET;
  logic [SIZE_W-1:0] min_reg = MIN_RESET;

  seg_res_t pending_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  logic [WGT_W-1:0] wcur;

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic void refill();
    for (int i = 0; i < NUM_VERTICES; i++) begin
      m_parent[i] = VTX_W'(i);
      m_rank[i] = '0;
      m_size[i] = SIZE_W'(1);
      m_thr[i] = k_reg;
      m_lbl[i] = '0;
      m_lvalid[i] = 1'b0;
    end
    m_sets = NUM_V_CNT;
    m_next_lbl = '0;
  endfunction

  function automatic logic [VTX_W-1:0] root_of(logic [VTX_W-1:0] v);
    logic [VTX_W-1:0] r;
    int unsigned guard;
    r = v;
    guard = 0;
    while (m_parent[r] != r && guard < NUM_VERTICES) begin
      r = m_parent[r];
      guard++;
    end
    m_parent[v] = r;
    return r;
  endfunction

  function automatic logic [VTX_W-1:0] link(logic [VTX_W-1:0] x, logic [VTX_W-1:0] y);
    logic [VTX_W-1:0] top, sub;
    int unsigned s;
    if (m_rank[x] > m_rank[y]) begin
      top = x;
      sub = y;
    end else begin
      top = y;
      sub = x;
      if (m_rank[x] == m_rank[y] && m_rank[y] < RANK_MAX) m_rank[y] = m_rank[y] + 1'b1;
    end
    m_parent[sub] = top;
    s = m_size[top] + m_size[sub];
    m_size[top] = (s > SIZE_MAX) ? SIZE_MAX : SIZE_W'(s);
    if (m_sets > 0) m_sets = m_sets - 1'b1;
    return top;
  endfunction

  function automatic seg_res_t segment_step(cmd_t cmd, logic [VTX_W-1:0] va,
                                            logic [VTX_W-1:0] vb, logic [WGT_W-1:0] w);
    seg_res_t r;
    logic [VTX_W-1:0] a, b, nr;
    int unsigned t, sz;
    r = '{merged: 1'b0, root: va, label: '0, count: '0};
    case (cmd)
      CMD_REINIT: refill();
      CMD_LABEL: begin
        a = root_of(va);
        r.root = a;
        if (!m_lvalid[a]) begin
          m_lvalid[a] = 1'b1;
          m_lbl[a] = m_next_lbl;
          if (m_next_lbl < LBL_MAX) m_next_lbl = m_next_lbl + 1'b1;
        end
        r.label = m_lbl[a][VTX_W-1:0];
      end
      default: begin
        a = root_of(va);
        b = root_of(vb);
        r.root = a;
        if (a != b) begin
          if (cmd == CMD_THR) begin
            if (w <= m_thr[a] && w <= m_thr[b]) begin
              nr = link(a, b);
              sz = m_size[nr];
              t = w + k_reg / ((sz != 0) ? sz : 1);
              m_thr[nr] = (t > THR_MAX) ? THR_MAX : THR_W'(t);
              r.merged = 1'b1;
              r.root = nr;
            end
          end else if (m_size[a] < min_reg || m_size[b] < min_reg) begin
            r.root = link(a, b);
            r.merged = 1'b1;
          end
        end
      end
    endcase
    r.count = m_sets;
    return r;
  endfunction

  // most gaps short, a few long
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic issue(cmd_t cmd, logic [VTX_W-1:0] va, logic [VTX_W-1:0] vb,
                       logic [WGT_W-1:0] w, bit typed, seg_res_t want);
    int unsigned gap;
    seg_res_t r;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_vertex_a <= va;
    in_vertex_b <= vb;
    in_edge_weight <= w;
    do @(posedge clk); while (busy);
    r = segment_step(cmd, va, vb, w);
    pending_q.insert(pending_q.size(), typed ? want : r);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(logic idx, logic [DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_K) k_reg = val[THR_W-1:0];
    else min_reg = val[SIZE_W-1:0];
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        $error("result with no transfer pending");
        errors++;
      end else begin
        seg_res_t e;
        e = pending_q.pop_front();
        if (out_merged !== e.merged) begin
          $error("merged expected %0d actual %0d", e.merged, out_merged);
          errors++;
        end
        if (out_root !== e.root) begin
          $error("root expected %0d actual %0d", e.root, out_root);
          errors++;
        end
        if (out_label !== e.label) begin
          $error("label expected %0d actual %0d", e.label, out_label);
          errors++;
        end
        if (out_component_count !== e.count) begin
          $error("component_count expected %0d actual %0d", e.count, out_component_count);
          errors++;
        end
      end
    end
  end

  dir_row_t dir_tab [12] = '{
    '{CMD_LABEL,  16'd0,     16'hffff, 17'h1ffff, 1'b1, '{1'b0, 16'd0, 16'd0, NUM_V_CNT}},
    '{CMD_LABEL,  16'hffff,  16'd0,    17'd0,     1'b1, '{1'b0, 16'hffff, 16'd1, NUM_V_CNT}},
    '{CMD_SMALL,  16'd5,     16'd5,    17'd0,     1'b1, '{1'b0, 16'd5, 16'd0, NUM_V_CNT}},
    '{CMD_THR,    16'd1,     16'd2,    17'd0,     1'b0, '0},
    '{CMD_THR,    16'd2,     16'd3,    17'd100,   1'b0, '0},
    '{CMD_THR,    16'd3,     16'd1,    17'd200,   1'b0, '0},
    '{CMD_THR,    16'hffff,  16'd0,    17'h1ffff, 1'b0, '0},
    '{CMD_SMALL,  16'd10,    16'd11,   17'h1ffff, 1'b0, '0},
    '{CMD_SMALL,  16'd11,    16'd1,    17'd0,     1'b0, '0},
    '{CMD_LABEL,  16'd2,     16'd0,    17'd0,     1'b0, '0},
    '{CMD_REINIT, 16'haaaa,  16'h5555, 17'h15555, 1'b1, '{1'b0, 16'haaaa, 16'd0, NUM_V_CNT}},
    '{CMD_LABEL,  16'd3,     16'd0,    17'd0,     1'b1, '{1'b0, 16'd3, 16'd0, NUM_V_CNT}}
  };

  initial begin
    logic [THR_W-1:0] ks [PHASES];
    logic [SIZE_W-1:0] mins [PHASES];
    cmd_t cmd;
    logic [VTX_W-1:0] va, vb;
    logic [WGT_W-1:0] w;
    int unsigned p;
    ks = '{24'd0, 24'hffffff, 24'd128000, 24'd3000, 24'd40000};
    mins = '{17'd1, 17'd65536, 17'd0, 17'd20, 17'd4};
    refill();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tab[i])
      issue(dir_tab[i].cmd, dir_tab[i].va, dir_tab[i].vb, dir_tab[i].w,
            dir_tab[i].typed, dir_tab[i].res);
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      reg_write(REG_K, DATA_W'(ks[ph]));
      reg_write(REG_MIN, DATA_W'(mins[ph]));
      // new k only reaches the threshold table through a refill
      issue(CMD_REINIT, VTX_W'($urandom), VTX_W'($urandom), WGT_W'($urandom), 1'b0, '0);
      wcur = '0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        p = $urandom_range(0, 99);
        cmd = (p < 45) ? CMD_THR : (p < 70) ? CMD_SMALL : CMD_LABEL;
        va = ($urandom_range(0, 9) < 8) ? VTX_W'($urandom_range(0, 63)) : VTX_W'($urandom);
        vb = ($urandom_range(0, 9) < 8) ? VTX_W'($urandom_range(0, 63)) : VTX_W'($urandom);
        if (cmd == CMD_THR) begin
          // edges must come in ascending weight order
          if ((WGT_W+1)'(wcur) + 400 <= (WGT_W+1)'(17'h1ffff))
            wcur = wcur + WGT_W'($urandom_range(0, 400));
          else wcur = 17'h1ffff;
          w = wcur;
        end else begin
          w = WGT_W'($urandom);
        end
        if (n == ITEMS_PER_PHASE / 2 && ph == 1) drain();
        issue(cmd, va, vb, w, 1'b0, '0);
      end
    end
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

### files.f
+incdir+rtl/core
rtl/core/gsuf_pkg.sv
rtl/core/gsuf_div.sv
rtl/core/graph_segmentation_union_find.sv
sim/tb_top.sv
